// File: sv/tes_pkg.sv
// Package for the tick event scheduler: widths, event bit positions, codes and shared types.
// Used by tes_tick and tick_event_scheduler; depends on nothing.
package tes_pkg;

  // Counter and register widths
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned REG_WIDTH   = 16;
  localparam int unsigned EV_WIDTH    = 6;
  localparam int unsigned IDX_WIDTH   = 3;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [REG_WIDTH-1:0]   reg_t;
  typedef logic [EV_WIDTH-1:0]    ev_t;

  // Event bit positions in the pending word
  localparam int unsigned EV_USB_OUT   = 0;
  localparam int unsigned EV_USB_IN    = 1;
  localparam int unsigned EV_SERVER    = 2;
  localparam int unsigned EV_RADIO     = 3;
  localparam int unsigned EV_HOTSWAP   = 4;
  localparam int unsigned EV_HEARTBEAT = 5;

  // Reset values of the registers
  localparam reg_t HB_PERIOD_RST  = REG_WIDTH'(1000);
  localparam reg_t BLINK_RST      = REG_WIDTH'(200);
  localparam reg_t HS_PERIOD_RST  = REG_WIDTH'(100);
  localparam reg_t USB_PERIOD_RST = REG_WIDTH'(16);
  localparam reg_t PING_START_RST = REG_WIDTH'(0);
  localparam reg_t PING_LIMIT_RST = REG_WIDTH'(16);

  // Item function codes (code 3 does nothing)
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_RAISE = 2'd2
  } func_e;

  // Register indexes
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_HB_PERIOD  = 3'd0,
    REG_BLINK      = 3'd1,
    REG_HS_PERIOD  = 3'd2,
    REG_USB_PERIOD = 3'd3,
    REG_PING_START = 3'd4,
    REG_PING_LIMIT = 3'd5
  } reg_idx_e;

  // Counter bank state
  typedef struct packed {
    cnt_t hb;
    cnt_t hs;
    cnt_t usb;
    cnt_t ping;
    cnt_t ping_int;
  } counters_t;

  // Configuration register values
  typedef struct packed {
    reg_t hb_period;
    reg_t blink_point;
    reg_t hs_period;
    reg_t usb_period;
    reg_t ping_start;
    reg_t ping_limit;
  } cfg_t;

  // Result of one tick
  typedef struct packed {
    ev_t  raise;
    logic blink;
  } tick_res_t;

endpackage

// File: sv/tes_tick.sv
// Tick update of the four down-counters: next counter values, raised events, blink pulse.
// Purely combinational; depends on tes_pkg.
module tes_tick (
  input  tes_pkg::counters_t cnt_i,
  input  tes_pkg::cfg_t      cfg_i,
  input  logic               usb_live_i,
  input  logic               queue_empty_i,
  output tes_pkg::counters_t cnt_o,
  output tes_pkg::tick_res_t res_o
);
  import tes_pkg::*;

  cnt_t                 ping_dec, hb_dec, hs_dec, usb_dec;
  logic [COUNT_WIDTH:0] ping_dbl;
  cnt_t                 ping_int_nxt;

  assign ping_dec = cnt_i.ping - COUNT_WIDTH'(1);
  assign hb_dec   = cnt_i.hb - COUNT_WIDTH'(1);
  assign hs_dec   = cnt_i.hs - COUNT_WIDTH'(1);
  assign usb_dec  = cnt_i.usb - COUNT_WIDTH'(1);

  // Doubled ping interval, saturating at all ones
  assign ping_dbl = {cnt_i.ping_int, 1'b0};
  always_comb begin
    ping_int_nxt = cnt_i.ping_int;
    if (cnt_i.ping_int < COUNT_WIDTH'(cfg_i.ping_limit)) begin
      ping_int_nxt = ping_dbl[COUNT_WIDTH] ? '1 : ping_dbl[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    cnt_o = cnt_i;
    res_o = '0;

    // Radio ping, runs only while the interval is nonzero
    if (cnt_i.ping_int != '0) begin
      cnt_o.ping = ping_dec;
      if (ping_dec == '0) begin
        res_o.raise[EV_RADIO] = queue_empty_i;
        cnt_o.ping_int        = ping_int_nxt;
        cnt_o.ping            = ping_int_nxt;
      end
    end

    // Heartbeat with blink point
    res_o.blink = (hb_dec == COUNT_WIDTH'(cfg_i.blink_point));
    cnt_o.hb    = hb_dec;
    if (hb_dec == '0) begin
      cnt_o.hb                  = COUNT_WIDTH'(cfg_i.hb_period);
      res_o.raise[EV_HEARTBEAT] = 1'b1;
    end

    // Hot-swap check
    cnt_o.hs = hs_dec;
    if (hs_dec == '0) begin
      cnt_o.hs                = COUNT_WIDTH'(cfg_i.hs_period);
      res_o.raise[EV_HOTSWAP] = 1'b1;
    end

    // USB poll, idle while zero
    if (cnt_i.usb != '0) begin
      cnt_o.usb = usb_dec;
      if (usb_dec == '0) begin
        res_o.raise[EV_USB_IN] = usb_live_i;
        cnt_o.usb              = COUNT_WIDTH'(cfg_i.usb_period);
      end
    end
  end

endmodule

// File: sv/tick_event_scheduler.sv
// Top level of the tick event scheduler: stream ports, state registers, result register.
// Depends on tes_pkg and tes_tick.
//
// Usage: each input word on the s_axis channel is one item. tuser carries the
// function (tick, clear masked events, raise masked events); tdata carries the
// event mask and the two status flags sampled on ticks. Every item gives
// exactly one result word on m_axis: the pending event bits after the item and
// the blink pulse (set only on a tick where the heartbeat count hits the blink
// point).
// The result sits in the output register on the cycle after acceptance.
// Throughput is one item per cycle while m_axis_tready is high, set by the
// single counter-update pass between the state and output registers.
// When the receiver stalls, the result is held and s_axis_tready drops until
// the held word is taken; no word is lost.
// Reset loads the default periods, reloads the counters, clears the pending
// bits and empties the output register. Register writes on cfg_* take effect
// at once and reload the matching counter; write them only while idle.
module tick_event_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // event_mask[5:0], usb_live, queue_empty
  input  logic [1:0]                    s_axis_tuser,  // func
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // pending[5:0], blink_start, zero
  // Register write port
  input  logic                          cfg_we_i,
  input  logic [tes_pkg::IDX_WIDTH-1:0] cfg_idx_i,
  input  tes_pkg::reg_t                 cfg_data_i
);
  import tes_pkg::*;

  cfg_t      cfg_q;
  counters_t cnt_q, cnt_d, cnt_tick;
  ev_t       pend_q, pend_d;
  tick_res_t tick_res;
  logic      out_valid_q;
  ev_t       out_pend_q;
  logic      out_blink_q;

  func_e     func;
  ev_t       mask;
  logic      s_fire;

  assign func   = func_e'(s_axis_tuser);
  assign mask   = s_axis_tdata[EV_WIDTH-1:0];
  assign s_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // Counter update for a tick
  tes_tick u_tick (
    .cnt_i        (cnt_q),
    .cfg_i        (cfg_q),
    .usb_live_i   (s_axis_tdata[6]),
    .queue_empty_i(s_axis_tdata[7]),
    .cnt_o        (cnt_tick),
    .res_o        (tick_res)
  );

  // Next pending word and counters per function
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    case (func)
      FUNC_TICK: begin
        pend_d = pend_q | tick_res.raise;
        cnt_d  = cnt_tick;
      end
      FUNC_CLEAR: pend_d = pend_q & ~mask;
      FUNC_RAISE: pend_d = pend_q | mask;
      default: pend_d = pend_q;
    endcase
  end

  // Registers, counters and pending bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hb_period   <= HB_PERIOD_RST;
      cfg_q.blink_point <= BLINK_RST;
      cfg_q.hs_period   <= HS_PERIOD_RST;
      cfg_q.usb_period  <= USB_PERIOD_RST;
      cfg_q.ping_start  <= PING_START_RST;
      cfg_q.ping_limit  <= PING_LIMIT_RST;
      cnt_q.hb          <= COUNT_WIDTH'(HB_PERIOD_RST);
      cnt_q.hs          <= COUNT_WIDTH'(HS_PERIOD_RST);
      cnt_q.usb         <= COUNT_WIDTH'(USB_PERIOD_RST);
      cnt_q.ping        <= COUNT_WIDTH'(PING_START_RST);
      cnt_q.ping_int    <= COUNT_WIDTH'(PING_START_RST);
      pend_q            <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HB_PERIOD: begin
          cfg_q.hb_period <= cfg_data_i;
          cnt_q.hb        <= COUNT_WIDTH'(cfg_data_i);
        end
        REG_BLINK: cfg_q.blink_point <= cfg_data_i;
        REG_HS_PERIOD: begin
          cfg_q.hs_period <= cfg_data_i;
          cnt_q.hs        <= COUNT_WIDTH'(cfg_data_i);
        end
        REG_USB_PERIOD: begin
          cfg_q.usb_period <= cfg_data_i;
          cnt_q.usb        <= COUNT_WIDTH'(cfg_data_i);
        end
        REG_PING_START: begin
          cfg_q.ping_start <= cfg_data_i;
          cnt_q.ping       <= COUNT_WIDTH'(cfg_data_i);
          cnt_q.ping_int   <= COUNT_WIDTH'(cfg_data_i);
        end
        REG_PING_LIMIT: cfg_q.ping_limit <= cfg_data_i;
        default: ;
      endcase
    end else if (s_fire) begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_pend_q  <= pend_d;
      out_blink_q <= (func == FUNC_TICK) && tick_res.blink;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_blink_q, out_pend_q};

  // Pending bits change only when an item is taken
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_fire |=> $stable(pend_q))
    else $error("pending bits changed without an accepted item");

  // Counters change only on an item or a register write
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_fire && !cfg_we_i) |=> $stable(cnt_q))
    else $error("counters changed while idle");

  // Non-tick items never give a blink pulse
  a_blink_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (func != FUNC_TICK)) |=> !out_blink_q)
    else $error("blink pulse on a non-tick item");

  // A nonzero heartbeat period never leaves the counter at zero after a tick
  a_hb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cfg_we_i && (func == FUNC_TICK) && (COUNT_WIDTH'(cfg_q.hb_period) != '0))
    |=> (cnt_q.hb != '0))
    else $error("heartbeat counter stuck at zero");

  // Result word reflects the pending register after the item
  a_out_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cfg_we_i) |=> (out_pend_q == pend_q))
    else $error("result pending word differs from pending register");

endmodule
